/* rtl/core/assert_macros.svh */
// Assertion macros used by the bound checker in cspr_checker.sv.
// Each macro samples on the rising edge of clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General concurrent assertion on a property.
`define CSPR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Overlapping implication: the consequent must hold in the cycle of the antecedent.
`define CSPR_ASSERT_IMPL(name, ante, cons, msg) \
  `CSPR_ASSERT(name, (ante) |-> (cons), msg)

`endif

/* rtl/core/cspr_pkg.sv */
package cspr_pkg;

  // Default widths of the datapath.
  localparam int unsigned CoordWidthDefault   = 32;
  localparam int unsigned TrigFracBitsDefault = 15;

  // Angle constants in whole degrees.
  localparam int unsigned YawWidth    = 9;
  localparam int unsigned FullTurn    = 360;
  localparam int unsigned HalfTurn    = 180;
  localparam int unsigned QuarterTurn = 90;
  localparam int unsigned ThreeQuarterTurn = 270;

  // Quarter-wave sine table: one entry per degree from 0 to 90 inclusive.
  localparam int unsigned SinEntries  = QuarterTurn + 1;
  localparam int unsigned TabIdxWidth = $clog2(SinEntries);

  // Pi in Q62 and one degree in radians in Q62.
  localparam longint unsigned PiQ62     = 64'hC90FDAA22168C234;
  localparam longint unsigned DegStepQ62 = PiQ62 / HalfTurn;

  // Number of Taylor terms beyond the first used when building the table.
  localparam int unsigned TaylorTerms = 10;

  // Configuration register indexes.
  localparam int unsigned CfgIdxWidth = 2;
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgCamPosX = 2'd0,
    CfgCamPosZ = 2'd1,
    CfgYaw     = 2'd2
  } cspr_cfg_idx_e;

  // Load enables of the pipeline stages after the input stage.
  typedef struct packed {
    logic prod;
    logic sum;
    logic res;
  } cspr_stage_en_t;

  // Unsigned quotient by shift and subtract, one bit per step. Only used at elaboration.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine of k degrees with frac fraction bits, rounded half up and clamped to 1.0.
  // The argument is formed in Q31 and the series is summed in Q31. Only used at elaboration.
  function automatic logic [63:0] sin_entry(input int unsigned k, input int unsigned frac);
    longint unsigned x62;
    longint unsigned x;
    longint unsigned term;
    longint unsigned t;
    longint          acc;
    longint          q;
    x62  = DegStepQ62 * longint'(k);
    x    = (x62 + (64'd1 << 30)) >> 31;
    term = x;
    acc  = longint'(x);
    for (int unsigned n = 1; n <= TaylorTerms; n++) begin
      t = (term * x) >> 31;
      t = udiv64(t, 64'(2 * n));
      t = (t * x) >> 31;
      t = udiv64(t, 64'(2 * n + 1));
      term = t;
      if (n % 2 == 1) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q = (acc + (longint'(1) << (30 - frac))) >>> (31 - frac);
    if (q > (longint'(1) << frac)) begin
      q = longint'(1) << frac;
    end
    return 64'(q);
  endfunction

endpackage

/* rtl/core/cspr_if.sv */
// Endpoint channel: one world-space endpoint per transaction.
interface cspr_point_if #(
  parameter int unsigned COORD_WIDTH = cspr_pkg::CoordWidthDefault
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, output point_x, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_z, output ready);
endinterface

// View channel: one camera-space point per transaction.
interface cspr_view_if #(
  parameter int unsigned COORD_WIDTH = cspr_pkg::CoordWidthDefault
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] view_x;
  logic signed [COORD_WIDTH-1:0] view_z;

  modport source (output valid, output view_x, output view_z, input ready);
  modport sink   (input valid, input view_x, input view_z, output ready);
endinterface

/* rtl/core/cspr_trig.sv */
module cspr_trig #(
  parameter int unsigned TRIG_FRAC_BITS = cspr_pkg::TrigFracBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [cspr_pkg::YawWidth-1:0]    yaw_i,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_neg_o
);
  import cspr_pkg::*;

  localparam int unsigned CoefWidth = TRIG_FRAC_BITS + 2;

  localparam logic [YawWidth-1:0] FullW    = YawWidth'(FullTurn);
  localparam logic [YawWidth-1:0] HalfW    = YawWidth'(HalfTurn);
  localparam logic [YawWidth-1:0] QuarterW = YawWidth'(QuarterTurn);
  localparam logic [YawWidth-1:0] ThreeQW  = YawWidth'(ThreeQuarterTurn);

  localparam logic signed [CoefWidth-1:0] CoefOne = {2'b01, {TRIG_FRAC_BITS{1'b0}}};

  logic [TRIG_FRAC_BITS:0] sin_tab [SinEntries];

  logic [YawWidth-1:0] ang;
  logic [YawWidth-1:0] s_idx;
  logic [YawWidth-1:0] c_idx;
  logic                s_neg;
  logic                c_neg;

  logic signed [CoefWidth-1:0] s_mag;
  logic signed [CoefWidth-1:0] c_mag;
  logic signed [CoefWidth-1:0] cos_d, cos_q;
  logic signed [CoefWidth-1:0] sin_d, sin_q;
  logic signed [CoefWidth-1:0] sin_neg_d, sin_neg_q;

  // Constant quarter-wave table, rounded to the coefficient precision.
  for (genvar k = 0; k < SinEntries; k++) begin : g_tab
    localparam logic [63:0] Entry = sin_entry(k, TRIG_FRAC_BITS);
    assign sin_tab[k] = Entry[TRIG_FRAC_BITS:0];
  end

  // Fold the angle into one full turn, then into the first quadrant.
  always_comb begin
    ang   = (yaw_i >= FullW) ? yaw_i - FullW : yaw_i;
    s_neg = 1'b0;
    c_neg = 1'b0;
    if (ang <= QuarterW) begin
      s_idx = ang;
      c_idx = QuarterW - ang;
    end else if (ang <= HalfW) begin
      s_idx = HalfW - ang;
      c_idx = ang - QuarterW;
      c_neg = 1'b1;
    end else if (ang <= ThreeQW) begin
      s_idx = ang - HalfW;
      c_idx = ThreeQW - ang;
      s_neg = 1'b1;
      c_neg = 1'b1;
    end else begin
      s_idx = FullW - ang;
      c_idx = ang - ThreeQW;
      s_neg = 1'b1;
    end
  end

  // Table reads and sign of each coefficient.
  always_comb begin
    s_mag     = {1'b0, sin_tab[s_idx[TabIdxWidth-1:0]]};
    c_mag     = {1'b0, sin_tab[c_idx[TabIdxWidth-1:0]]};
    sin_d     = s_neg ? -s_mag : s_mag;
    cos_d     = c_neg ? -c_mag : c_mag;
    sin_neg_d = -sin_d;
  end

  // Coefficients are refreshed every cycle from the yaw register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q     <= CoefOne;
      sin_q     <= '0;
      sin_neg_q <= '0;
    end else begin
      cos_q     <= cos_d;
      sin_q     <= sin_d;
      sin_neg_q <= sin_neg_d;
    end
  end

  assign cos_o     = cos_q;
  assign sin_o     = sin_q;
  assign sin_neg_o = sin_neg_q;

endmodule

/* rtl/core/cspr_mix.sv */
module cspr_mix #(
  parameter int unsigned COORD_WIDTH    = cspr_pkg::CoordWidthDefault,
  parameter int unsigned TRIG_FRAC_BITS = cspr_pkg::TrigFracBitsDefault
) (
  input  logic                             clk_i,
  input  cspr_pkg::cspr_stage_en_t         en_i,
  input  logic signed [COORD_WIDTH:0]      a_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] c1_i,
  input  logic signed [COORD_WIDTH:0]      b_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] c2_i,
  output logic signed [COORD_WIDTH-1:0]    res_o
);
  import cspr_pkg::*;

  localparam int unsigned DiffWidth = COORD_WIDTH + 1;
  localparam int unsigned CoefWidth = TRIG_FRAC_BITS + 2;
  localparam int unsigned LoWidth   = DiffWidth / 2;
  localparam int unsigned HiWidth   = DiffWidth - LoWidth;
  localparam int unsigned PLoWidth  = LoWidth + 1 + CoefWidth;
  localparam int unsigned PHiWidth  = HiWidth + CoefWidth;
  localparam int unsigned SLoWidth  = PLoWidth + 1;
  localparam int unsigned SHiWidth  = PHiWidth + 1;
  localparam int unsigned AccWidth  = DiffWidth + TRIG_FRAC_BITS + 3;
  localparam int unsigned TopWidth  = AccWidth - TRIG_FRAC_BITS - COORD_WIDTH + 1;

  localparam logic signed [AccWidth-1:0] Half =
    AccWidth'(1) <<< (TRIG_FRAC_BITS - 1);
  localparam logic signed [COORD_WIDTH-1:0] SatMax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] SatMin = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [LoWidth:0]    a_lo, b_lo;
  logic signed [HiWidth-1:0]  a_hi, b_hi;

  logic signed [PLoWidth-1:0] p_alo_q, p_blo_q;
  logic signed [PHiWidth-1:0] p_ahi_q, p_bhi_q;
  logic signed [SLoWidth-1:0] s_lo_d, s_lo_q;
  logic signed [SHiWidth-1:0] s_hi_d, s_hi_q;
  logic signed [AccWidth-1:0] acc;
  logic [TopWidth-1:0]        acc_top;
  logic signed [COORD_WIDTH-1:0] res_d, res_q;

  // Split each difference into an unsigned low half and a signed high half.
  assign a_lo = {1'b0, a_i[LoWidth-1:0]};
  assign b_lo = {1'b0, b_i[LoWidth-1:0]};
  assign a_hi = a_i[DiffWidth-1:LoWidth];
  assign b_hi = b_i[DiffWidth-1:LoWidth];

  // Partial products.
  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      p_alo_q <= a_lo * c1_i;
      p_blo_q <= b_lo * c2_i;
      p_ahi_q <= a_hi * c1_i;
      p_bhi_q <= b_hi * c2_i;
    end
  end

  // Sum the low and the high partial products separately.
  assign s_lo_d = SLoWidth'(p_alo_q) + SLoWidth'(p_blo_q);
  assign s_hi_d = SHiWidth'(p_ahi_q) + SHiWidth'(p_bhi_q);

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      s_lo_q <= s_lo_d;
      s_hi_q <= s_hi_d;
    end
  end

  // Recombine, round half up, drop the fraction bits and saturate.
  always_comb begin
    acc     = (AccWidth'(s_hi_q) <<< LoWidth) + AccWidth'(s_lo_q) + Half;
    acc_top = acc[AccWidth-1:TRIG_FRAC_BITS+COORD_WIDTH-1];
    if (acc_top == '0 || acc_top == '1) begin
      res_d = acc[TRIG_FRAC_BITS+COORD_WIDTH-1:TRIG_FRAC_BITS];
    end else if (acc[AccWidth-1]) begin
      res_d = SatMin;
    end else begin
      res_d = SatMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.res) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/core/camera_space_point_rotate.sv */
// Camera-space point rotation.
// The point channel takes one world-space endpoint (point_x, point_z, signed Q16.16)
// per transaction. The view channel returns exactly one camera-space point per
// endpoint, in order: the camera position is subtracted and the difference is
// rotated by the yaw in whole degrees, rounded once and saturated to Q16.16.
// The configuration port writes camera_pos_x, camera_pos_z and yaw_degrees by index;
// write it only while no transaction is in flight. Yaw values of 360 and above
// are taken modulo 360.
// Throughput is one endpoint per cycle while the view receiver does not stall.
// The pipeline has four register stages (difference, partial products, partial sums,
// rounded result), and view valid comes from the valid flag of the last one.
// When the view receiver stalls, the result holds and the empty stages behind it
// keep filling; point ready falls only once all four stages hold an endpoint.
// Reset clears the camera position and the yaw to zero and empties the pipeline.
module camera_space_point_rotate #(
  parameter int unsigned COORD_WIDTH    = cspr_pkg::CoordWidthDefault,
  parameter int unsigned TRIG_FRAC_BITS = cspr_pkg::TrigFracBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cspr_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]           cfg_wdata_i,
  cspr_point_if.sink                       point_i,
  cspr_view_if.source                      view_o
);
  import cspr_pkg::*;

  localparam int unsigned DiffWidth = COORD_WIDTH + 1;
  localparam int unsigned CoefWidth = TRIG_FRAC_BITS + 2;

  logic signed [COORD_WIDTH-1:0] cam_x_q;
  logic signed [COORD_WIDTH-1:0] cam_z_q;
  logic [YawWidth-1:0]           yaw_q;

  logic signed [CoefWidth-1:0] cos_c;
  logic signed [CoefWidth-1:0] sin_c;
  logic signed [CoefWidth-1:0] sin_neg_c;

  logic v1_q, v2_q, v3_q, v4_q;
  logic load1, load2, load3, load4;
  logic in_take;
  cspr_stage_en_t en;

  logic signed [DiffWidth-1:0] dx_d, dx_q;
  logic signed [DiffWidth-1:0] dz_d, dz_q;

  logic signed [COORD_WIDTH-1:0] res_x;
  logic signed [COORD_WIDTH-1:0] res_z;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_z_q <= '0;
      yaw_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCamPosX: cam_x_q <= cfg_wdata_i;
        CfgCamPosZ: cam_z_q <= cfg_wdata_i;
        CfgYaw:     yaw_q   <= cfg_wdata_i[YawWidth-1:0];
        default: ;
      endcase
    end
  end

  // Sine and cosine of the current yaw.
  cspr_trig #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .yaw_i     (yaw_q),
    .cos_o     (cos_c),
    .sin_o     (sin_c),
    .sin_neg_o (sin_neg_c)
  );

  // A stage loads when it is empty or its content moves on in the same cycle.
  assign load4   = !v4_q || view_o.ready;
  assign load3   = !v3_q || load4;
  assign load2   = !v2_q || load3;
  assign load1   = !v1_q || load2;
  assign in_take = point_i.valid && load1;

  assign en.prod = load2 && v1_q;
  assign en.sum  = load3 && v2_q;
  assign en.res  = load4 && v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (load1) v1_q <= point_i.valid;
      if (load2) v2_q <= v1_q;
      if (load3) v3_q <= v2_q;
      if (load4) v4_q <= v3_q;
    end
  end

  // Exact differences, one bit wider than the coordinates.
  assign dx_d = DiffWidth'(point_i.point_x) - DiffWidth'(cam_x_q);
  assign dz_d = DiffWidth'(point_i.point_z) - DiffWidth'(cam_z_q);

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      dx_q <= dx_d;
      dz_q <= dz_d;
    end
  end

  // view_x = dx*cos + dz*sin.
  cspr_mix #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_mix_x (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (dx_q),
    .c1_i  (cos_c),
    .b_i   (dz_q),
    .c2_i  (sin_c),
    .res_o (res_x)
  );

  // view_z = dz*cos - dx*sin.
  cspr_mix #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_mix_z (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (dz_q),
    .c1_i  (cos_c),
    .b_i   (dx_q),
    .c2_i  (sin_neg_c),
    .res_o (res_z)
  );

  assign point_i.ready = load1;
  assign view_o.valid  = v4_q;
  assign view_o.view_x = res_x;
  assign view_o.view_z = res_z;

endmodule

/* rtl/core/cspr_checker.sv */
`include "assert_macros.svh"

module cspr_checker #(
  parameter int unsigned COORD_WIDTH = cspr_pkg::CoordWidthDefault
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [COORD_WIDTH-1:0] view_x_i,
  input logic [COORD_WIDTH-1:0] view_z_i
);
  import cspr_pkg::*;

  localparam int unsigned Depth    = 4;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [CntWidth-1:0] DepthC = CntWidth'(Depth);

  logic                in_xfer;
  logic                out_xfer;
  logic [CntWidth-1:0] cnt_d, cnt_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Endpoints taken whose results have not yet been delivered.
  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (out_xfer && !in_xfer) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled result keeps its value.
  `CSPR_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(view_x_i) && $stable(view_z_i), "view result changed while stalled")

  // No result without an endpoint in flight.
  `CSPR_ASSERT_IMPL(a_no_invent, out_valid_i, cnt_q != '0, "view result without a pending endpoint")

  // The pipeline never holds more endpoints than it has stages.
  `CSPR_ASSERT(a_depth, cnt_q <= DepthC, "more endpoints in flight than pipeline stages")

  // Input back-pressure only arises from a stalled result.
  `CSPR_ASSERT_IMPL(a_ready_cause, !in_ready_i, out_valid_i && !out_ready_i && cnt_q == DepthC, "point ready low without a full stalled pipeline")

endmodule

bind camera_space_point_rotate cspr_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_cspr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (point_i.valid),
  .in_ready_i  (point_i.ready),
  .out_valid_i (view_o.valid),
  .out_ready_i (view_o.ready),
  .view_x_i    (view_o.view_x),
  .view_z_i    (view_o.view_z)
);

/* verif/view_point_checker.sv */
`timescale 1ns / 100ps

// Watches the configuration port and both channels, predicts the camera-space
// point of every accepted endpoint and compares it with the view transaction.
module view_point_checker #(
  parameter int unsigned COORD_WIDTH    = cspr_pkg::CoordWidthDefault,
  parameter int unsigned TRIG_FRAC_BITS = cspr_pkg::TrigFracBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cspr_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]           cfg_wdata_i,
  input  logic                             point_valid_i,
  input  logic                             point_ready_i,
  input  logic signed [COORD_WIDTH-1:0]    point_x_i,
  input  logic signed [COORD_WIDTH-1:0]    point_z_i,
  input  logic                             view_valid_i,
  input  logic                             view_ready_i,
  input  logic signed [COORD_WIDTH-1:0]    view_x_i,
  input  logic signed [COORD_WIDTH-1:0]    view_z_i,
  output int                               pending_o,
  output int                               errors_o
);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] view_x;
    logic signed [COORD_WIDTH-1:0] view_z;
  } view_point_t;

  // Saturation bounds of a signed coordinate.
  localparam longint CoordHi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint CoordLo = -CoordHi - 1;

  // Copy of the configuration registers as the block should hold them.
  longint                            cam_x;
  longint                            cam_z;
  logic [cspr_pkg::YawWidth-1:0]     yaw;

  // Sine of 0 to 90 degrees with TRIG_FRAC_BITS fraction bits.
  longint sine_lut [0:cspr_pkg::QuarterTurn];

  view_point_t expected_views [$];

  // Taylor series of sin(k degrees) in Q31, rounded half up and clamped to one.
  function automatic longint taylor_sine_q(input int unsigned k);
    longint unsigned arg;
    longint unsigned term;
    longint unsigned t;
    longint          total;
    longint          q;
    arg   = (cspr_pkg::DegStepQ62 * longint'(k) + (64'd1 << 30)) >> 31;
    term  = arg;
    total = longint'(arg);
    for (int unsigned n = 1; n <= 10; n++) begin
      t    = ((term * arg) >> 31) / longint'(2 * n);
      t    = ((t * arg) >> 31) / longint'(2 * n + 1);
      term = t;
      total = (n % 2 == 1) ? total - longint'(t) : total + longint'(t);
    end
    if (total < 0) begin
      total = 0;
    end
    q = (total + (longint'(1) <<< (30 - TRIG_FRAC_BITS))) >>> (31 - TRIG_FRAC_BITS);
    if (q > (longint'(1) <<< TRIG_FRAC_BITS)) begin
      q = longint'(1) <<< TRIG_FRAC_BITS;
    end
    return q;
  endfunction

  // One sum of two products, rounded once and saturated to the coordinate range.
  function automatic logic signed [COORD_WIDTH-1:0] round_sat(input longint a, input longint c1,
                                                              input longint b, input longint c2);
    longint acc;
    acc = (a * c1 + b * c2 + (longint'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    if (acc > CoordHi) begin
      acc = CoordHi;
    end else if (acc < CoordLo) begin
      acc = CoordLo;
    end
    return acc[COORD_WIDTH-1:0];
  endfunction

  // Camera-space position of one world-space endpoint.
  function automatic view_point_t rotate_point(input logic signed [COORD_WIDTH-1:0] px,
                                               input logic signed [COORD_WIDTH-1:0] pz);
    longint      dx;
    longint      dz;
    longint      sn;
    longint      cs;
    int unsigned ang;
    view_point_t res;
    dx  = longint'(px) - cam_x;
    dz  = longint'(pz) - cam_z;
    ang = int'(yaw) % cspr_pkg::FullTurn;
    if (ang <= cspr_pkg::QuarterTurn) begin
      sn = sine_lut[ang];
      cs = sine_lut[cspr_pkg::QuarterTurn - ang];
    end else if (ang <= cspr_pkg::HalfTurn) begin
      sn = sine_lut[cspr_pkg::HalfTurn - ang];
      cs = -sine_lut[ang - cspr_pkg::QuarterTurn];
    end else if (ang <= cspr_pkg::ThreeQuarterTurn) begin
      sn = -sine_lut[ang - cspr_pkg::HalfTurn];
      cs = -sine_lut[cspr_pkg::ThreeQuarterTurn - ang];
    end else begin
      sn = -sine_lut[cspr_pkg::FullTurn - ang];
      cs = sine_lut[ang - cspr_pkg::ThreeQuarterTurn];
    end
    res.view_x = round_sat(dx, cs, dz, sn);
    res.view_z = round_sat(dz, cs, dx, -sn);
    return res;
  endfunction

  initial begin
    for (int unsigned k = 0; k <= cspr_pkg::QuarterTurn; k++) begin
      sine_lut[k] = taylor_sine_q(k);
    end
  end

  // Register writes, endpoint predictions and view comparisons.
  always @(posedge clk_i or negedge rst_ni) begin
    view_point_t want;
    if (!rst_ni) begin
      cam_x     = 0;
      cam_z     = 0;
      yaw       = '0;
      pending_o = 0;
      errors_o  = 0;
      expected_views.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cspr_pkg::CfgCamPosX: cam_x = longint'(signed'(cfg_wdata_i));
          cspr_pkg::CfgCamPosZ: cam_z = longint'(signed'(cfg_wdata_i));
          cspr_pkg::CfgYaw:     yaw   = cfg_wdata_i[cspr_pkg::YawWidth-1:0];
          default: ;
        endcase
      end
      if (point_valid_i && point_ready_i) begin
        expected_views.push_back(rotate_point(point_x_i, point_z_i));
      end
      if (view_valid_i && view_ready_i) begin
        if (expected_views.size() == 0) begin
          $error("view transaction with no endpoint outstanding: x %0d z %0d",
                 view_x_i, view_z_i);
          errors_o++;
        end else begin
          want = expected_views.pop_front();
          if (view_x_i !== want.view_x) begin
            $error("view_x mismatch: expected %0d, actual %0d", want.view_x, view_x_i);
            errors_o++;
          end
          if (view_z_i !== want.view_z) begin
            $error("view_z mismatch: expected %0d, actual %0d", want.view_z, view_z_i);
            errors_o++;
          end
        end
      end
      pending_o = expected_views.size();
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

// Drives endpoints and camera settings into the rotation block and gives the verdict.
module testbench;

  localparam int unsigned COORD_WIDTH = cspr_pkg::CoordWidthDefault;
  localparam logic [COORD_WIDTH-1:0] CoordMax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] CoordMin = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  // The one index that no register answers to.
  localparam logic [cspr_pkg::CfgIdxWidth-1:0] CfgIdxSpare = 2'd3;
  localparam int CycleLimit = 200000;
  localparam int HoldOffCycles = 60;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [cspr_pkg::CfgIdxWidth-1:0] cfg_idx_i;
  logic [COORD_WIDTH-1:0]           cfg_wdata_i;

  int pending;
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_pending;
  int cycle_count;

  cspr_point_if #(.COORD_WIDTH(COORD_WIDTH)) point_ch ();
  cspr_view_if  #(.COORD_WIDTH(COORD_WIDTH)) view_ch ();

  camera_space_point_rotate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .point_i     (point_ch),
    .view_o      (view_ch)
  );

  view_point_checker #(.COORD_WIDTH(COORD_WIDTH)) checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .point_valid_i (point_ch.valid),
    .point_ready_i (point_ch.ready),
    .point_x_i     (point_ch.point_x),
    .point_z_i     (point_ch.point_z),
    .view_valid_i  (view_ch.valid),
    .view_ready_i  (view_ch.ready),
    .view_x_i      (view_ch.view_x),
    .view_z_i      (view_ch.view_z),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a run that has not finished by now is hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // View receiver: random stalls, and a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    view_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        view_ch.ready <= 1'b0;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HoldOffCycles;
        view_ch.ready <= 1'b0;
      end else begin
        view_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // A coordinate near the centre, at an extreme, or anywhere at all.
  function automatic logic [COORD_WIDTH-1:0] pick_coord(input logic [COORD_WIDTH-1:0] centre);
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0:          return CoordMax;
      1:          return CoordMin;
      2, 3, 4, 5: return centre + {{(COORD_WIDTH-24){r[23]}}, r[23:0]};
      default:    return r;
    endcase
  endfunction

  function automatic logic [cspr_pkg::YawWidth-1:0] pick_yaw();
    case ($urandom_range(7))
      0:       return '0;
      1:       return cspr_pkg::YawWidth'(cspr_pkg::FullTurn - 1);
      2:       return cspr_pkg::YawWidth'(cspr_pkg::FullTurn);
      3:       return cspr_pkg::YawWidth'($urandom_range(511, cspr_pkg::FullTurn));
      4:       return cspr_pkg::YawWidth'($urandom_range(4) * cspr_pkg::QuarterTurn);
      default: return cspr_pkg::YawWidth'($urandom_range(cspr_pkg::FullTurn - 1));
    endcase
  endfunction

  // Offers one endpoint after a random gap and returns once it has been taken.
  task automatic send_point(input logic [COORD_WIDTH-1:0] px, input logic [COORD_WIDTH-1:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      point_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    point_ch.valid   <= 1'b1;
    point_ch.point_x <= px;
    point_ch.point_z <= pz;
    do @(posedge clk_i); while (!point_ch.ready);
  endtask

  // Waits until every endpoint has come back and the pipeline is empty.
  task automatic drain_pipe();
    point_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all three registers, with a write to the spare index in front.
  task automatic apply_setting(input logic [COORD_WIDTH-1:0] cx, input logic [COORD_WIDTH-1:0] cz,
                               input logic [cspr_pkg::YawWidth-1:0] yaw);
    logic [COORD_WIDTH-1:0] yaw_word;
    yaw_word = $urandom();
    yaw_word[cspr_pkg::YawWidth-1:0] = yaw;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgIdxSpare;
    cfg_wdata_i <= $urandom();
    @(posedge clk_i);
    cfg_idx_i   <= cspr_pkg::CfgCamPosX;
    cfg_wdata_i <= cx;
    @(posedge clk_i);
    cfg_idx_i   <= cspr_pkg::CfgCamPosZ;
    cfg_wdata_i <= cz;
    @(posedge clk_i);
    cfg_idx_i   <= cspr_pkg::CfgYaw;
    cfg_wdata_i <= yaw_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Stimulus: directed corners first, then random settings and endpoints.
  initial begin
    logic [COORD_WIDTH-1:0] cam_x;
    logic [COORD_WIDTH-1:0] cam_z;
    hold_pending = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 59;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= cspr_pkg::CfgCamPosX;
    cfg_wdata_i <= '0;
    point_ch.valid <= 1'b0;
    point_ch.point_x <= '0;
    point_ch.point_z <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: identity rotation about the origin.
    send_point(CoordMax, CoordMax);
    send_point(CoordMin, CoordMin);
    send_point(CoordMax, CoordMin);
    send_point(CoordMin, CoordMax);
    send_point('0, '0);
    send_point('1, 1);
    send_point(1, '1);
    drain_pipe();

    // Camera at the far corners, so the differences need the extra bit and saturate.
    apply_setting(CoordMin, CoordMax, 9'd45);
    send_point(CoordMax, CoordMin);
    send_point(CoordMin, CoordMax);
    send_point(CoordMax, CoordMax);
    send_point('0, '0);
    drain_pipe();

    // A full turn must behave as no turn.
    apply_setting(CoordMax, CoordMin, 9'(cspr_pkg::FullTurn));
    send_point(CoordMin, CoordMax);
    send_point('0, '0);
    send_point(CoordMax, CoordMin);
    drain_pipe();

    // The remaining quadrant boundaries and the largest yaw code.
    apply_setting(32'h0001_0000, 32'hFFFF_0000, 9'(cspr_pkg::HalfTurn));
    send_point(CoordMax, CoordMin);
    send_point(32'h0003_8000, 32'hFFFE_4000);
    drain_pipe();
    apply_setting(32'h0000_8000, '0, 9'(cspr_pkg::QuarterTurn));
    send_point(CoordMax, 32'h0002_0000);
    send_point(CoordMin, CoordMin);
    drain_pipe();
    apply_setting('0, 32'h0000_8000, 9'(cspr_pkg::ThreeQuarterTurn));
    send_point(32'h0002_0000, CoordMax);
    send_point(CoordMax, CoordMin);
    drain_pipe();
    apply_setting(32'h1234_5678, 32'hEDCB_A988, 9'd511);
    send_point(32'h1234_0000, 32'hEDCC_0000);
    send_point(CoordMin, CoordMax);

    // Random part in three idling phases of four settings each.
    for (int phase = 0; phase < 3; phase++) begin
      for (int s = 0; s < 4; s++) begin
        drain_pipe();
        case (phase)
          0: begin
            send_idle_pct = 19;
            recv_idle_pct = 59;
          end
          1: begin
            send_idle_pct = 59;
            recv_idle_pct = 19;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        cam_x = pick_coord('0);
        cam_z = pick_coord('0);
        apply_setting(cam_x, cam_z, pick_yaw());
        // With no idling, hold the view side off so the pipeline fills and stalls.
        if (phase == 2 && s == 0) begin
          hold_pending = 1'b1;
        end
        repeat (108) begin
          send_point(pick_coord(cam_x), pick_coord(cam_z));
        end
      end
    end

    drain_pipe();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* camera_space_point_rotate.f */
+incdir+rtl/core
rtl/core/cspr_pkg.sv
rtl/core/cspr_if.sv
rtl/core/cspr_trig.sv
rtl/core/cspr_mix.sv
rtl/core/camera_space_point_rotate.sv
rtl/core/cspr_checker.sv
verif/view_point_checker.sv
verif/testbench.sv
